// File: design/assert_macros.svh
// assertion macros shared by the activation unit
// expects clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never be seen at a clock edge outside reset
`define NAU_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// antecedent at an edge implies the consequent property
`define NAU_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/nau_pkg.sv
// shared types, constants and lookup tables of the activation unit
// no dependencies
package nau_pkg;

	// data format
	localparam int DATA_W    = 16;
	localparam int MODE_W    = 3;
	localparam int FRAC_BITS = 8;

	// table geometry: segments over [-8,8)
	localparam int TABLE_SEGMENTS = 64;
	localparam int SEG_W          = $clog2(TABLE_SEGMENTS);
	localparam int SPAN_W         = FRAC_BITS + 4;
	localparam int FRAC_W         = SPAN_W - SEG_W;
	localparam int TAB_IDX_W      = SEG_W + 1;
	localparam int X_OFFSET       = 8 << FRAC_BITS;

	// leaky slope 655/65536
	localparam int LEAK_NUM   = 655;
	localparam int LEAK_W     = 10;
	localparam int LEAK_SHIFT = 16;

	// multiplier operands and product
	localparam int MUL_A_W = DATA_W;
	localparam int MUL_B_W = (FRAC_W > LEAK_W) ? FRAC_W : LEAK_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// function limits
	localparam logic signed [DATA_W-1:0] SIG_LO  = 16'sd0;
	localparam logic signed [DATA_W-1:0] SIG_HI  = 16'sd256;
	localparam logic signed [DATA_W-1:0] TANH_LO = -16'sd256;
	localparam logic signed [DATA_W-1:0] TANH_HI = 16'sd256;

	typedef enum logic [MODE_W-1:0] {
		MODE_IDENTITY = 3'd0,
		MODE_RELU     = 3'd1,
		MODE_SIGMOID  = 3'd2,
		MODE_TANH     = 3'd3,
		MODE_LEAKY    = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		OP_PASS,
		OP_SIG,
		OP_TANH,
		OP_LEAKY
	} op_t;

	// classified item handed from front to back
	typedef struct packed {
		op_t                       op;
		logic signed [DATA_W-1:0]  value;
		logic [SEG_W-1:0]          seg;
		logic [FRAC_W-1:0]         frac;
	} front_item_t;

	// sigmoid at breakpoints -8 + i/4, Q7.8
	localparam logic signed [DATA_W-1:0] SIG_TAB [0:TABLE_SEGMENTS] = '{
		16'sd0,   16'sd0,   16'sd0,   16'sd0,   16'sd0,   16'sd0,   16'sd0,   16'sd0,
		16'sd1,   16'sd1,   16'sd1,   16'sd1,   16'sd2,   16'sd2,   16'sd3,   16'sd4,
		16'sd5,   16'sd6,   16'sd8,   16'sd10,  16'sd12,  16'sd15,  16'sd19,  16'sd24,
		16'sd31,  16'sd38,  16'sd47,  16'sd57,  16'sd69,  16'sd82,  16'sd97,  16'sd112,
		16'sd128,
		16'sd144, 16'sd159, 16'sd174, 16'sd187, 16'sd199, 16'sd209, 16'sd218, 16'sd225,
		16'sd232, 16'sd237, 16'sd241, 16'sd244, 16'sd246, 16'sd248, 16'sd250, 16'sd251,
		16'sd252, 16'sd253, 16'sd254, 16'sd254, 16'sd255, 16'sd255, 16'sd255, 16'sd255,
		16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'sd256
	};

	// tanh at breakpoints -8 + i/4, Q7.8
	localparam logic signed [DATA_W-1:0] TANH_TAB [0:TABLE_SEGMENTS] = '{
		-16'sd256, -16'sd256, -16'sd256, -16'sd256, -16'sd256, -16'sd256, -16'sd256,
		-16'sd256, -16'sd256, -16'sd256, -16'sd256, -16'sd256, -16'sd256, -16'sd256,
		-16'sd256, -16'sd256, -16'sd256, -16'sd256, -16'sd256,
		-16'sd255, -16'sd255, -16'sd254, -16'sd253, -16'sd250, -16'sd247, -16'sd241,
		-16'sd232, -16'sd217, -16'sd195, -16'sd163, -16'sd118, -16'sd63,
		16'sd0,
		16'sd63,  16'sd118, 16'sd163, 16'sd195, 16'sd217, 16'sd232, 16'sd241, 16'sd247,
		16'sd250, 16'sd253, 16'sd254, 16'sd255, 16'sd255,
		16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'sd256,
		16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'sd256,
		16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'sd256
	};

endpackage

// File: design/nau_front.sv
// front end: mode register, input handshake and item classification
// depends on nau_pkg
module nau_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [nau_pkg::MODE_W-1:0]         cfg_data,
	input  logic                               start,
	input  logic signed [nau_pkg::DATA_W-1:0]  x_value,
	input  logic                               queue_full,
	output logic                               busy,
	output logic                               push,
	output nau_pkg::front_item_t               push_item,
	output logic [nau_pkg::MODE_W-1:0]         mode
);

	localparam int P_W = nau_pkg::DATA_W + 1;

	logic [nau_pkg::MODE_W-1:0] mode_q;
	logic signed [P_W-1:0]      pos;
	logic                       below;
	logic                       above;

	// activation mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= nau_pkg::MODE_IDENTITY;
		end else if (cfg_write) begin
			mode_q <= cfg_data;
		end
	end

	assign mode = mode_q;

	// handshake: accept while the queue has room
	assign busy = queue_full;
	assign push = start && !queue_full;

	// position inside the table span and out-of-range flags
	always_comb begin
		pos   = $signed({x_value[nau_pkg::DATA_W-1], x_value}) + P_W'(nau_pkg::X_OFFSET);
		below = pos[P_W-1];
		above = !below && (pos[P_W-2:nau_pkg::SPAN_W] != '0);
	end

	// classify the item for the back end
	always_comb begin
		push_item.op    = nau_pkg::OP_PASS;
		push_item.value = x_value;
		push_item.seg   = pos[nau_pkg::SPAN_W-1:nau_pkg::FRAC_W];
		push_item.frac  = pos[nau_pkg::FRAC_W-1:0];
		case (mode_q)
			nau_pkg::MODE_RELU: begin
				if (x_value[nau_pkg::DATA_W-1]) begin
					push_item.value = '0;
				end
			end
			nau_pkg::MODE_SIGMOID: begin
				if (below) begin
					push_item.value = nau_pkg::SIG_LO;
				end else if (above) begin
					push_item.value = nau_pkg::SIG_HI;
				end else begin
					push_item.op = nau_pkg::OP_SIG;
				end
			end
			nau_pkg::MODE_TANH: begin
				if (below) begin
					push_item.value = nau_pkg::TANH_LO;
				end else if (above) begin
					push_item.value = nau_pkg::TANH_HI;
				end else begin
					push_item.op = nau_pkg::OP_TANH;
				end
			end
			nau_pkg::MODE_LEAKY: begin
				push_item.op = nau_pkg::OP_LEAKY;
			end
			default: begin
				push_item.op = nau_pkg::OP_PASS;
			end
		endcase
	end

endmodule

// File: design/nau_queue.sv
// short fifo of classified items between front and back
// depends on nau_pkg
module nau_queue #(
	parameter int DEPTH = nau_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  nau_pkg::front_item_t  push_item,
	input  logic                  pop,
	output nau_pkg::front_item_t  head_item,
	output logic                  not_empty,
	output logic                  full
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	nau_pkg::front_item_t store_q [DEPTH];
	logic [IDX_W-1:0]     wr_ptr_q;
	logic [IDX_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 push_ok;
	logic                 pop_ok;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign push_ok   = push && !full;
	assign pop_ok    = pop && not_empty;
	assign head_item = store_q[rd_ptr_q];

	// item storage
	always_ff @(posedge clk) begin
		if (push_ok) begin
			store_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push_ok, pop_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/nau_back.sv
// back end: table read and multiply, then rounding, add and saturation
// depends on nau_pkg
module nau_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	input  nau_pkg::front_item_t               item,
	output logic                               done,
	output logic signed [nau_pkg::DATA_W-1:0]  y_value
);

	localparam int DW    = nau_pkg::DATA_W;
	localparam int SUM_W = DW + 2;
	localparam int RND_W = nau_pkg::PROD_W + 1;

	logic [nau_pkg::TAB_IDX_W-1:0] idx_lo;
	logic [nau_pkg::TAB_IDX_W-1:0] idx_hi;
	logic signed [DW-1:0]          lo_v;
	logic signed [DW-1:0]          hi_v;
	logic signed [DW:0]            delta;
	logic [DW:0]                   delta_mag;
	logic [DW:0]                   neg_x;
	logic signed [DW-1:0]          base_c;
	logic [nau_pkg::MUL_A_W-1:0]   mul_a;
	logic [nau_pkg::MUL_B_W-1:0]   mul_b;
	logic                          neg_c;
	logic                          leak_c;

	logic                          valid_s1;
	logic signed [DW-1:0]          base_s1;
	logic [nau_pkg::PROD_W-1:0]    prod_s1;
	logic                          neg_s1;
	logic                          leak_s1;

	logic [RND_W-1:0]              rounded;
	logic [DW:0]                   q_mag;
	logic signed [SUM_W-1:0]       sum;
	logic signed [DW-1:0]          sat;

	logic                          valid_s2;
	logic signed [DW-1:0]          y_s2;

	// stage 1: table neighbors, slope and operand selection
	always_comb begin
		idx_lo    = {1'b0, item.seg};
		idx_hi    = idx_lo + 1'b1;
		lo_v      = (item.op == nau_pkg::OP_TANH) ? nau_pkg::TANH_TAB[idx_lo]
		                                          : nau_pkg::SIG_TAB[idx_lo];
		hi_v      = (item.op == nau_pkg::OP_TANH) ? nau_pkg::TANH_TAB[idx_hi]
		                                          : nau_pkg::SIG_TAB[idx_hi];
		delta     = $signed({hi_v[DW-1], hi_v}) - $signed({lo_v[DW-1], lo_v});
		delta_mag = delta[DW] ? (DW+1)'(-delta) : delta;
		neg_x     = (DW+1)'(-$signed({item.value[DW-1], item.value}));

		base_c = item.value;
		mul_a  = '0;
		mul_b  = '0;
		neg_c  = 1'b0;
		leak_c = 1'b0;
		case (item.op)
			nau_pkg::OP_SIG, nau_pkg::OP_TANH: begin
				base_c = lo_v;
				mul_a  = delta_mag[nau_pkg::MUL_A_W-1:0];
				mul_b  = nau_pkg::MUL_B_W'(item.frac);
				neg_c  = delta[DW];
			end
			nau_pkg::OP_LEAKY: begin
				if (item.value[DW-1]) begin
					base_c = '0;
					mul_a  = neg_x[nau_pkg::MUL_A_W-1:0];
					mul_b  = nau_pkg::MUL_B_W'(nau_pkg::LEAK_NUM);
					neg_c  = 1'b1;
					leak_c = 1'b1;
				end
			end
			default: begin
				base_c = item.value;
			end
		endcase
	end

	// stage 1 registers, product registered
	always_ff @(posedge clk) begin
		base_s1 <= base_c;
		prod_s1 <= mul_a * mul_b;
		neg_s1  <= neg_c;
		leak_s1 <= leak_c;
	end

	// stage 2: round the product, apply it to the base, saturate
	always_comb begin
		if (leak_s1) begin
			rounded = (RND_W'(prod_s1) + RND_W'(1 << (nau_pkg::LEAK_SHIFT - 1)))
			          >> nau_pkg::LEAK_SHIFT;
		end else begin
			rounded = (RND_W'(prod_s1) + RND_W'(1 << (nau_pkg::FRAC_W - 1)))
			          >> nau_pkg::FRAC_W;
		end
		q_mag = rounded[DW:0];
		if (neg_s1) begin
			sum = SUM_W'(base_s1) - $signed({1'b0, q_mag});
		end else begin
			sum = SUM_W'(base_s1) + $signed({1'b0, q_mag});
		end
		if (sum > SUM_W'(2**(DW-1) - 1)) begin
			sat = {1'b0, {(DW-1){1'b1}}};
		end else if (sum < -$signed(SUM_W'(2**(DW-1)))) begin
			sat = {1'b1, {(DW-1){1'b0}}};
		end else begin
			sat = sum[DW-1:0];
		end
	end

	// stage 2 output register
	always_ff @(posedge clk) begin
		y_s2 <= sat;
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign done    = valid_s2;
	assign y_value = y_s2;

endmodule

// File: design/neural_activation_unit.sv
// top level of the activation unit: front, item queue and back end
// depends on nau_pkg, nau_front, nau_queue, nau_back and assert_macros.svh
`include "assert_macros.svh"

// One Q7.8 sample is taken per clock whenever start is high and busy is low.
// Its activation is on y_value with done high for exactly one cycle, once the
// item has passed through the queue and then the stage 1 registers and the
// stage 2 output register of the back end. The back end drains the item queue
// every cycle, so busy stays low in normal use and the sustained rate is one
// item per clock. Sigmoid and tanh come from 65-point constant tables read in
// the first back-end stage, interpolated by one multiply; leaky ReLU uses the
// same multiplier. Write cfg_data with cfg_write only while no item is in
// flight; codes above four give the identity. There is no result backpressure.
module neural_activation_unit #(
	parameter int QUEUE_DEPTH = nau_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [nau_pkg::MODE_W-1:0]         cfg_data,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [nau_pkg::DATA_W-1:0]  x_value,
	output logic                               done,
	output logic signed [nau_pkg::DATA_W-1:0]  y_value
);

	logic                       push;
	nau_pkg::front_item_t       push_item;
	nau_pkg::front_item_t       head_item;
	logic                       not_empty;
	logic                       queue_full;
	logic [nau_pkg::MODE_W-1:0] mode;
	logic                       relu_done;
	logic                       sig_done;
	logic                       sig_in_range;

	// accept and classify
	nau_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.start      (start),
		.x_value    (x_value),
		.queue_full (queue_full),
		.busy       (busy),
		.push       (push),
		.push_item  (push_item),
		.mode       (mode)
	);

	// item queue, drained every cycle it holds an item
	nau_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (not_empty),
		.head_item (head_item),
		.not_empty (not_empty),
		.full      (queue_full)
	);

	// compute
	nau_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (not_empty),
		.item       (head_item),
		.done       (done),
		.y_value    (y_value)
	);

	// result qualifiers for the checks
	assign relu_done    = done && (mode == nau_pkg::MODE_RELU);
	assign sig_done     = done && (mode == nau_pkg::MODE_SIGMOID);
	assign sig_in_range = !y_value[nau_pkg::DATA_W-1] && (y_value <= nau_pkg::SIG_HI);

	// checks
	`NAU_ASSERT_NEVER(a_queue_never_full, busy, "item queue filled up")
	`NAU_ASSERT_IMPLY(a_fixed_latency, start && !busy, ##3 done, "result latency broken")
	`NAU_ASSERT_IMPLY(a_relu_nonneg, relu_done, !y_value[nau_pkg::DATA_W-1], "negative relu")
	`NAU_ASSERT_IMPLY(a_sigmoid_range, sig_done, sig_in_range, "sigmoid result out of range")

endmodule

// File: tb/nau_checker.sv
`timescale 1ns / 100ps
// checker of the activation unit: tracks the mode register, predicts each item's
// activation in Q7.8 and compares it with the strobed result; depends on nau_pkg
module nau_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [nau_pkg::MODE_W-1:0]         cfg_data,
	input  logic                               start,
	input  logic                               busy,
	input  logic signed [nau_pkg::DATA_W-1:0]  x_value,
	input  logic                               done,
	input  logic signed [nau_pkg::DATA_W-1:0]  y_value,
	output int                                 mismatches,
	output int                                 outstanding
);

	localparam int DW          = nau_pkg::DATA_W;
	localparam int MW          = nau_pkg::MODE_W;
	localparam int FB          = nau_pkg::FRAC_BITS;
	localparam int SEGS        = nau_pkg::TABLE_SEGMENTS;
	localparam int SPAN        = 16 << FB;
	localparam int HALF_RANGE  = 8 << FB;
	localparam int ONE_Q       = 1 << FB;
	localparam int EXP_FRAC    = 30;
	localparam int SERIES_FRAC = 40;
	localparam int SERIES_LEN  = 24;
	localparam int LEAK_MUL    = 655;
	localparam int LEAK_DIV    = 65536;

	int sig_lut [0:SEGS];
	int tanh_lut [0:SEGS];
	int mismatch_cnt = 0;
	logic [MW-1:0] act_mode;
	logic signed [DW-1:0] y_pending_q [$];

	assign mismatches = mismatch_cnt;

	// unsigned division rounded to nearest, ties up
	function automatic longint unsigned div_nearest(longint unsigned num,
			longint unsigned den);
		return (2 * num + den) / (2 * den);
	endfunction

	// e^-(r/SEGS) for r in [0, SEGS], by a truncated series
	function automatic longint unsigned exp_series(longint unsigned r);
		longint unsigned term, acc;
		int k;
		term = 64'd1 << SERIES_FRAC;
		acc = term;
		for (k = 1; k <= SERIES_LEN; k++) begin
			term = term * r / (SEGS * k);
			if (k % 2 == 1)
				acc = acc - term;
			else
				acc = acc + term;
		end
		return (acc + (64'd1 << (SERIES_FRAC - EXP_FRAC - 1))) >> (SERIES_FRAC - EXP_FRAC);
	endfunction

	// e^-(num/SEGS): fraction from the series, whole part by repeated e^-1
	function automatic longint unsigned exp_decay(longint unsigned num);
		longint unsigned v, e1, n, i;
		n = num / SEGS;
		v = exp_series(num % SEGS);
		e1 = exp_series(SEGS);
		for (i = 0; i < n; i++)
			v = (v * e1 + (64'd1 << (EXP_FRAC - 1))) >> EXP_FRAC;
		return v;
	endfunction

	function automatic int clamp16(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return int'(v);
	endfunction

	// breakpoint values of sigmoid and tanh over [-8,8]
	initial begin : build_luts
		longint unsigned one_e, a, e, e2, s;
		longint d, t;
		int i;
		one_e = 64'd1 << EXP_FRAC;
		for (i = 0; i <= SEGS; i++) begin
			d = 16 * i - 8 * SEGS;
			a = (d < 0) ? -d : d;
			e = exp_decay(a);
			e2 = exp_decay(2 * a);
			if (d >= 0)
				s = div_nearest(one_e << FB, one_e + e);
			else
				s = div_nearest(e << FB, one_e + e);
			t = longint'(div_nearest((one_e - e2) << FB, one_e + e2));
			if (d < 0)
				t = -t;
			sig_lut[i] = clamp16(longint'(s));
			tanh_lut[i] = clamp16(t);
		end
	end

	// linear interpolation between breakpoints, saturating outside [-8,8)
	function automatic int interp(bit use_tanh, int x);
		longint p, scaled, k, r, delta, prod, base;
		longint unsigned mag, q;
		p = x + HALF_RANGE;
		if (p < 0)
			return use_tanh ? -ONE_Q : 0;
		if (p >= SPAN)
			return ONE_Q;
		scaled = p * SEGS;
		k = scaled / SPAN;
		r = scaled % SPAN;
		base = use_tanh ? tanh_lut[k] : sig_lut[k];
		delta = (use_tanh ? tanh_lut[k + 1] : sig_lut[k + 1]) - base;
		prod = delta * r;
		mag = (prod < 0) ? -prod : prod;
		q = div_nearest(mag, SPAN);
		return clamp16((prod < 0) ? base - longint'(q) : base + longint'(q));
	endfunction

	// negative side scaled by the leak slope, rounded half away from zero
	function automatic int leak(int x);
		longint unsigned mag;
		if (x >= 0)
			return x;
		mag = longint'(-x) * LEAK_MUL;
		return -int'(div_nearest(mag, LEAK_DIV));
	endfunction

	function automatic logic signed [DW-1:0] activate(logic [MW-1:0] m,
			logic signed [DW-1:0] x);
		int xi, y;
		xi = x;
		case (m)
			nau_pkg::MODE_RELU:    y = (xi > 0) ? xi : 0;
			nau_pkg::MODE_SIGMOID: y = interp(1'b0, xi);
			nau_pkg::MODE_TANH:    y = interp(1'b1, xi);
			nau_pkg::MODE_LEAKY:   y = leak(xi);
			default:               y = xi;
		endcase
		return DW'(clamp16(y));
	endfunction

	// result first, then the new item, then a register write
	always @(posedge clk or negedge arst_n) begin : watch
		logic signed [DW-1:0] want;
		if (!arst_n) begin
			act_mode = nau_pkg::MODE_IDENTITY;
			y_pending_q.delete();
		end else begin
			if (done) begin
				if (y_pending_q.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("%0t: result %0d with no item outstanding", $time, y_value);
					mismatch_cnt++;
				end else begin
					want = y_pending_q.pop_front();
					if (y_value !== want) begin
						if (mismatch_cnt < 10)
							$display("%0t: y_value expected %0d got %0d", $time, want, y_value);
						mismatch_cnt++;
					end
				end
			end
			if (start && !busy)
				y_pending_q.push_back(activate(act_mode, x_value));
			if (cfg_write)
				act_mode = cfg_data;
		end
		outstanding = y_pending_q.size();
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// top of the activation unit bench: clock, reset, mode phases and item stimulus
// depends on nau_pkg, neural_activation_unit and nau_checker
module tb;

	localparam int DW = nau_pkg::DATA_W;
	localparam int MW = nau_pkg::MODE_W;

	// codes outside the defined modes, expected to act as identity
	localparam logic [MW-1:0] MODE_SPARE_5 = 3'd5;
	localparam logic [MW-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [MW-1:0] MODE_SPARE_7 = 3'd7;

	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 180;
	localparam int STEADY_PHASE  = 4;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 2000;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [MW-1:0] cfg_data;
	logic start;
	logic busy;
	logic signed [DW-1:0] x_value;
	logic done;
	logic signed [DW-1:0] y_value;
	int mismatches;
	int outstanding;
	int stall_cycles = 0;
	bit steady_feed = 0;

	logic [MW-1:0] phase_modes [PHASES];
	int corner_vals [8] = '{-32768, 32767, 0, -1, -2048, -2049, 2047, 2048};

	neural_activation_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.start     (start),
		.busy      (busy),
		.x_value   (x_value),
		.done      (done),
		.y_value   (y_value)
	);

	nau_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.start       (start),
		.busy        (busy),
		.x_value     (x_value),
		.done        (done),
		.y_value     (y_value),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mode writes only once the pipe has drained
	task automatic set_mode(logic [MW-1:0] m);
		start <= 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_write <= 1'b1;
		cfg_data <= m;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// one item, with random idle cycles ahead of it unless feeding steadily
	task automatic feed(logic signed [DW-1:0] x);
		while (!steady_feed && $urandom_range(0, 99) < 33) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		x_value <= x;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// mostly the interpolated span, some range borders, some full range
	function automatic int pick_sample();
		int roll, base;
		roll = $urandom_range(0, 99);
		if (roll < 20)
			return int'($urandom_range(0, 65535)) - 32768;
		if (roll < 32) begin
			case ($urandom_range(0, 4))
				0: base = -2048;
				1: base = 2048;
				2: base = -32768;
				3: base = 32767;
				default: base = 0;
			endcase
			return base + int'($urandom_range(0, 16)) - 8;
		end
		return int'($urandom_range(0, 4800)) - 2400;
	endfunction

	// cycles with no item and no result; a hang ends the run
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int p, i;
		phase_modes = '{nau_pkg::MODE_IDENTITY, nau_pkg::MODE_RELU, nau_pkg::MODE_SIGMOID,
			nau_pkg::MODE_TANH, nau_pkg::MODE_LEAKY, MODE_SPARE_5, MODE_SPARE_6,
			MODE_SPARE_7, nau_pkg::MODE_SIGMOID, nau_pkg::MODE_TANH};
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_data = '0;
		start = 1'b0;
		x_value = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: corners under the reset mode, then each defined mode
		for (i = 0; i < 4; i++)
			feed(DW'(corner_vals[i]));
		set_mode(nau_pkg::MODE_RELU);
		for (i = 0; i < 4; i++)
			feed(DW'(corner_vals[i]));
		set_mode(nau_pkg::MODE_LEAKY);
		for (i = 0; i < 4; i++)
			feed(DW'(corner_vals[i]));
		set_mode(nau_pkg::MODE_SIGMOID);
		for (i = 0; i < 8; i++)
			feed(DW'(corner_vals[i]));
		set_mode(nau_pkg::MODE_TANH);
		for (i = 0; i < 8; i++)
			feed(DW'(corner_vals[i]));

		// random phases over every mode code, one phase without idling
		for (p = 0; p < PHASES; p++) begin
			set_mode(phase_modes[p]);
			steady_feed = (p == STEADY_PHASE);
			for (i = 0; i < PHASE_ITEMS; i++)
				feed(DW'(pick_sample()));
		end

		start <= 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/nau_pkg.sv
design/nau_front.sv
design/nau_queue.sv
design/nau_back.sv
design/neural_activation_unit.sv
tb/nau_checker.sv
tb/tb.sv
